// File: sv/dhc_pkg.sv
// ----------------------------------------------------------------------------
// dhc_pkg
// Shared types and constants of the dead/hot channel classifier.
// ----------------------------------------------------------------------------
package dhc_pkg;

	localparam int MAX_CH  = 1024;
	localparam int ADDR_W  = $clog2(MAX_CH);
	localparam int NUM_W   = ADDR_W + 1;
	localparam int CNT_W   = 32;
	localparam int BIT_W   = $clog2(CNT_W);
	localparam int SUM_W   = 42;
	localparam int MD_W    = CNT_W + 1;
	localparam int FRAC_W  = 16;
	localparam int PROD_W  = FRAC_W + MD_W;
	localparam int SHARE_W = 17;
	localparam int DIVD_W  = NUM_W + 16;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_MEDZ  = 2'd2,
		ST_OVF   = 2'd3
	} status_t;

	typedef enum logic {
		REG_DEAD_FRACTION  = 1'b0,
		REG_HOT_MULTIPLIER = 1'b1
	} reg_index_t;

	typedef enum logic [3:0] {
		S_LOAD, S_SEL, S_MED, S_MULD, S_MULH, S_THR, S_DIVD, S_DIVH, S_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: sv/dhc_ram.sv
// ----------------------------------------------------------------------------
// dhc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dhc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/dhc_div.sv
// ----------------------------------------------------------------------------
// dhc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dhc_div
	import dhc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIVD_W-1:0]  dividend,
	input  logic [NUM_W-1:0]   divisor,
	output div_stat_t          stat,
	output logic [SHARE_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DIVD_W + 1);

	logic [DIVD_W-1:0] quo_q;
	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  dsr_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [NUM_W:0]    trial;
	logic              fits;

	// Shift in the next dividend bit; the remainder stays below the divisor.
	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], fits};
			rem_q <= fits ? NUM_W'(trial - {1'b0, dsr_q}) : trial[NUM_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q[SHARE_W-1:0];

endmodule

// File: sv/median_dead_hot_channel_classifier_core.sv
// ----------------------------------------------------------------------------
// median_dead_hot_channel_classifier_core
// Loads per-channel hit counts, finds the doubled median by bitwise radix
// selection over the count store, classifies dead and hot channels and
// reports their shares of the channel count.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    hit_count, last_item
// out      output     out_valid / out_ready  status, dead_share, hot_share,
//                                            channel_total, hit_sum,
//                                            median_doubled
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// Items are loaded while in_ready is high. An item with last_item set closes
// the set, after which the block is busy with median selection (one pass over
// the stored counts per count bit through the single RAM read port), the
// multiplies for both thresholds, a threshold pass and the divisions for both
// shares; a zero doubled median skips straight to the result. The result then
// sits in the output register; loading of the next set resumes while it waits.
// Reset is asynchronous and clears control state only; the count store needs
// no clearing because only entries of the current set are read.
// ----------------------------------------------------------------------------
module median_dead_hot_channel_classifier_core
	import dhc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        hit_count,
	input  logic               last_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [SHARE_W-1:0] dead_share,
	output logic [SHARE_W-1:0] hot_share,
	output logic [NUM_W-1:0]   channel_total,
	output logic [SUM_W-1:0]   hit_sum,
	output logic [MD_W-1:0]    median_doubled,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [FRAC_W-1:0]  cfg_data
);

	state_t state_q, state_d;

	logic [FRAC_W-1:0]  df_q, hm_q;
	logic [NUM_W-1:0]   num_q;
	logic [SUM_W-1:0]   sum_q;
	logic               ovf_q;
	logic [NUM_W-1:0]   idx_q;
	logic               rv_s1;
	logic [BIT_W-1:0]   bit_q;
	logic [CNT_W-1:0]   pa_q, pb_q;
	logic [NUM_W-1:0]   ka_q, kb_q, ca_q, cb_q;
	logic [MD_W-1:0]    md_q;
	logic [PROD_W-1:0]  dthr_q, hthr_q;
	logic [NUM_W-1:0]   dead_q, hot_q;
	logic [SHARE_W-1:0] dsh_q, hsh_q;
	logic               out_valid_q;

	logic               accept, room, issue, pass_end, out_free;
	logic [CNT_W-1:0]   count_in, rdata, hi_mask;
	logic [CNT_W:0]     low_mask;
	logic [NUM_W-1:0]   num_next;
	logic [MD_W-1:0]    md_sum;
	logic [FRAC_W-1:0]  mul_a;
	logic [PROD_W-1:0]  product;
	logic               match_a, match_b, is_dead, is_hot;
	logic               div_start;
	logic [DIVD_W-1:0]  div_dividend;
	logic [SHARE_W-1:0] div_quot;
	div_stat_t          div_stat;

	assign count_in = hit_count[CNT_W-1:0];
	assign in_ready = (state_q == S_LOAD);
	assign accept   = in_valid && in_ready;
	assign room     = (num_q < NUM_W'(MAX_CH));
	assign num_next = room ? num_q + 1'b1 : num_q;
	assign out_free = !out_valid_q || out_ready;

	// Store reads walk the kept channels; data returns in the next cycle.
	assign issue    = (state_q == S_SEL || state_q == S_THR) && (idx_q < num_q);
	assign pass_end = (idx_q == num_q) && !rv_s1;

	dhc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CH)) u_store (
		.clk   (clk),
		.we    (accept && room),
		.waddr (num_q[ADDR_W-1:0]),
		.wdata (count_in),
		.re    (issue),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	// Both order statistics share a pass: entries whose bits above the current
	// bit match the prefix so far and whose current bit is zero are counted.
	assign low_mask = ((CNT_W+1)'(1) << ({1'b0, bit_q} + 1'b1)) - 1'b1;
	assign hi_mask  = ~low_mask[CNT_W-1:0];
	assign match_a  = (((rdata ^ pa_q) & hi_mask) == '0) && !rdata[bit_q];
	assign match_b  = (((rdata ^ pb_q) & hi_mask) == '0) && !rdata[bit_q];
	assign md_sum   = MD_W'(pa_q) + MD_W'(pb_q);

	// One multiplier forms both thresholds in consecutive cycles.
	assign mul_a   = (state_q == S_MULD) ? df_q : hm_q;
	assign product = PROD_W'(mul_a) * PROD_W'(md_q);

	// Dead when count * 2^17 < dead_fraction * md; hot when count * 2^9 exceeds
	// hot_multiplier * md.
	assign is_dead = {rdata, 17'b0} < dthr_q;
	assign is_hot  = PROD_W'({rdata, 9'b0}) > hthr_q;

	assign div_start    = (state_q == S_THR && pass_end) ||
	                      (state_q == S_DIVD && div_stat.done);
	assign div_dividend = (state_q == S_THR) ? {dead_q, 16'b0} : {hot_q, 16'b0};

	dhc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (num_q),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (accept && last_item) begin
					state_d = S_SEL;
				end
			end
			S_SEL: begin
				if (pass_end && bit_q == '0) begin
					state_d = S_MED;
				end
			end
			S_MED: begin
				state_d = (md_sum == '0) ? S_DONE : S_MULD;
			end
			S_MULD: state_d = S_MULH;
			S_MULH: state_d = S_THR;
			S_THR: begin
				if (pass_end) begin
					state_d = S_DIVD;
				end
			end
			S_DIVD: begin
				if (div_stat.done) begin
					state_d = S_DIVH;
				end
			end
			S_DIVH: begin
				if (div_stat.done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			df_q        <= FRAC_W'(3277);
			hm_q        <= FRAC_W'(1280);
			num_q       <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_DEAD_FRACTION) begin
					df_q <= cfg_data;
				end else begin
					hm_q <= cfg_data;
				end
			end
			rv_s1 <= issue;
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			// A new result replaces the one leaving in the same cycle.
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						num_q <= num_next;
						if (room) begin
							sum_q <= sum_q + SUM_W'(count_in);
						end else begin
							ovf_q <= 1'b1;
						end
						idx_q <= '0;
					end
				end
				S_SEL: begin
					if (pass_end) begin
						idx_q <= '0;
					end
				end
				S_MULH: idx_q <= '0;
				S_DONE: begin
					if (out_free) begin
						num_q       <= '0;
						sum_q       <= '0;
						ovf_q       <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				if (accept && last_item) begin
					pa_q  <= '0;
					pb_q  <= '0;
					ca_q  <= '0;
					cb_q  <= '0;
					bit_q <= BIT_W'(CNT_W - 1);
					kb_q  <= num_next >> 1;
					ka_q  <= num_next[0] ? (num_next >> 1) : (num_next >> 1) - 1'b1;
				end
			end
			S_SEL: begin
				if (rv_s1) begin
					ca_q <= ca_q + NUM_W'(match_a);
					cb_q <= cb_q + NUM_W'(match_b);
				end
				if (pass_end) begin
					if (ka_q >= ca_q) begin
						pa_q[bit_q] <= 1'b1;
						ka_q        <= ka_q - ca_q;
					end
					if (kb_q >= cb_q) begin
						pb_q[bit_q] <= 1'b1;
						kb_q        <= kb_q - cb_q;
					end
					ca_q  <= '0;
					cb_q  <= '0;
					bit_q <= bit_q - 1'b1;
				end
			end
			S_MED: begin
				md_q  <= md_sum;
				dsh_q <= '0;
				hsh_q <= '0;
			end
			S_MULD: dthr_q <= product;
			S_MULH: begin
				hthr_q <= product;
				dead_q <= '0;
				hot_q  <= '0;
			end
			S_THR: begin
				if (rv_s1) begin
					dead_q <= dead_q + NUM_W'(is_dead);
					hot_q  <= hot_q + NUM_W'(is_hot);
				end
			end
			S_DIVD: begin
				if (div_stat.done) begin
					dsh_q <= div_quot;
				end
			end
			S_DIVH: begin
				if (div_stat.done) begin
					hsh_q <= div_quot;
				end
			end
			S_DONE: begin
				if (out_free) begin
					status         <= ovf_q ? ST_OVF : ((md_q == '0) ? ST_MEDZ : ST_OK);
					dead_share     <= dsh_q;
					hot_share      <= hsh_q;
					channel_total  <= num_q;
					hit_sum        <= sum_q;
					median_doubled <= md_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		num_q <= NUM_W'(MAX_CH))
		else $error("channel count exceeds store depth");

	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_item |=> !in_ready)
		else $error("input still ready after set closed");

	a_never_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != ST_EMPTY) && (channel_total != '0))
		else $error("result for an empty set");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == S_DIVD || state_q == S_DIVH))
		else $error("divider busy outside share computation");
`endif

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dead/hot channel classifier. Sets of hit counts
// are streamed in with random idle bursts on both sides. A behavioral model
// predicts the status, shares, channel count, sum and doubled median of every
// closed set, and each result item is compared field by field.
// ----------------------------------------------------------------------------
module testbench
	import dhc_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic [31:0] hit;
		logic        last;
	} chan_item_t;

	typedef struct packed {
		status_t             st;
		logic [SHARE_W-1:0]  dsh;
		logic [SHARE_W-1:0]  hsh;
		logic [NUM_W-1:0]    total;
		logic [SUM_W-1:0]    sum;
		logic [MD_W-1:0]     md;
	} set_summary_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [31:0]        hit_count;
	logic               last_item;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic [SHARE_W-1:0] dead_share;
	logic [SHARE_W-1:0] hot_share;
	logic [NUM_W-1:0]   channel_total;
	logic [SUM_W-1:0]   hit_sum;
	logic [MD_W-1:0]    median_doubled;
	logic               cfg_we;
	logic               cfg_index;
	logic [FRAC_W-1:0]  cfg_data;

	// Items waiting for the driver, and summaries waiting for the output.
	chan_item_t   pending_items[$];
	set_summary_t expected_summaries[$];

	// Model state: the set being loaded and the two thresholds.
	logic [31:0]    model_counts[$];
	logic [SUM_W-1:0] model_sum;
	bit             model_overflow;
	logic [15:0]    model_dead_frac;
	logic [15:0]    model_hot_mult;

	int  error_count = 0;
	int  cycle_count = 0;
	int  in_idle;
	int  out_idle;
	bit  calm_phase;

	median_dead_hot_channel_classifier_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.hit_count(hit_count), .last_item(last_item),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .dead_share(dead_share), .hot_share(hot_share),
		.channel_total(channel_total), .hit_sum(hit_sum),
		.median_doubled(median_doubled),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	// Feeds one channel into the model and, when it closes the set, works
	// out the summary the block must report.
	task automatic classify_channel(input chan_item_t item);
		set_summary_t res;
		logic [31:0]  sorted[$];
		int           n;
		int           dead;
		int           hot;
		logic [127:0] lhs;
		logic [127:0] rhs;
		if (model_counts.size() < MAX_CH) begin
			model_counts = {model_counts, item.hit};
			model_sum = model_sum + item.hit;
		end else begin
			model_overflow = 1'b1;
		end
		if (!item.last)
			return;
		res = '0;
		n = model_counts.size();
		if (n == 0) begin
			res.st = ST_EMPTY;
		end else begin
			sorted = model_counts;
			sorted.sort();
			if (n % 2)
				res.md = {1'b0, sorted[n / 2]} << 1;
			else
				res.md = {1'b0, sorted[n / 2]} + {1'b0, sorted[n / 2 - 1]};
			res.st = ST_OK;
			if (res.md == 0) begin
				res.st = ST_MEDZ;
			end else begin
				dead = 0;
				hot = 0;
				foreach (model_counts[k]) begin
					lhs = 128'(model_counts[k]) << 17;
					rhs = 128'(model_dead_frac) * 128'(res.md);
					if (lhs < rhs)
						dead++;
					lhs = 128'(model_counts[k]) << 9;
					rhs = 128'(model_hot_mult) * 128'(res.md);
					if (lhs > rhs)
						hot++;
				end
				res.dsh = SHARE_W'((64'(dead) << 16) / n);
				res.hsh = SHARE_W'((64'(hot) << 16) / n);
			end
			if (model_overflow)
				res.st = ST_OVF;
			res.total = NUM_W'(n);
			res.sum = model_sum;
		end
		expected_summaries = {expected_summaries, res};
		model_counts.delete();
		model_sum = '0;
		model_overflow = 1'b0;
	endtask

	task automatic queue_channel(input logic [31:0] hit, input bit last);
		chan_item_t item;
		item.hit = hit;
		item.last = last;
		pending_items = {pending_items, item};
		classify_channel(item);
	endtask

	// A random set: counts clustered around a level, with some dead and some
	// hot outliers, so that both thresholds are crossed in most sets.
	task automatic queue_random_set(input int len);
		logic [31:0] level;
		logic [31:0] hit;
		int          kind;
		level = (($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 5000));
		for (int k = 0; k < len; k++) begin
			kind = $urandom_range(0, 9);
			if (kind == 0)
				hit = $urandom_range(0, 3);
			else if (kind == 1)
				hit = $urandom;
			else if (kind == 2)
				hit = level * $urandom_range(4, 12);
			else
				hit = level + $urandom_range(0, 20) - 10;
			queue_channel(hit, k == len - 1);
		end
	endtask

	// Waits until the block is idle, then writes one register.
	task automatic write_register(input reg_index_t idx, input logic [15:0] value);
		while (pending_items.size() != 0 || expected_summaries.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DEAD_FRACTION)
			model_dead_frac = value;
		else
			model_hot_mult = value;
	endtask

	// Input driver: presents queued items, with bursts of idle cycles.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			hit_count <= '0;
			last_item <= 1'b0;
			in_idle <= 0;
		end else begin
			if (in_valid && in_ready)
				void'(pending_items.pop_front());
			if (in_valid && !in_ready) begin
				// Hold the item until it is taken.
			end else if (in_idle > 0) begin
				in_idle <= in_idle - 1;
				in_valid <= 1'b0;
			end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
				in_idle <= $urandom_range(0, 4);
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				in_valid <= 1'b1;
				hit_count <= pending_items[0].hit;
				last_item <= pending_items[0].last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output monitor: checks each accepted result and stalls at random.
	always @(posedge clk) begin
		set_summary_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_idle <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_summaries.size() == 0) begin
					report_mismatch("unexpected result", 64'(status), 0);
				end else begin
					want = expected_summaries.pop_front();
					if (status != want.st)
						report_mismatch("status", status, want.st);
					if (dead_share != want.dsh)
						report_mismatch("dead_share", dead_share, want.dsh);
					if (hot_share != want.hsh)
						report_mismatch("hot_share", hot_share, want.hsh);
					if (channel_total != want.total)
						report_mismatch("channel_total", channel_total, want.total);
					if (hit_sum != want.sum)
						report_mismatch("hit_sum", hit_sum, want.sum);
					if (median_doubled != want.md)
						report_mismatch("median_doubled", median_doubled, want.md);
				end
			end
			if (out_idle > 0) begin
				out_idle <= out_idle - 1;
				out_ready <= 1'b0;
			end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
				out_idle <= $urandom_range(0, 4);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DEAD_FRACTION;
		cfg_data = '0;
		calm_phase = 1'b0;
		model_sum = '0;
		model_overflow = 1'b0;
		model_dead_frac = 16'd3277;
		model_hot_mult = 16'd1280;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single channels, zero median, extremes, a
		// typical set with dead and hot channels.
		queue_channel(32'd0, 1'b1);
		queue_channel(32'hFFFF_FFFF, 1'b1);
		queue_channel(32'd7, 1'b1);
		queue_channel(32'd0, 1'b0);
		queue_channel(32'd0, 1'b0);
		queue_channel(32'd9, 1'b1);
		queue_channel(32'h5555_5555, 1'b0);
		queue_channel(32'hAAAA_AAAA, 1'b1);
		queue_channel(32'd100, 1'b0);
		queue_channel(32'd1, 1'b0);
		queue_channel(32'd2000, 1'b0);
		queue_channel(32'd100, 1'b0);
		queue_channel(32'd101, 1'b1);
		queue_channel(32'hFFFF_FFFF, 1'b0);
		queue_channel(32'hFFFF_FFFF, 1'b1);

		// Threshold extremes, all on small sets.
		write_register(REG_DEAD_FRACTION, 16'hFFFF);
		write_register(REG_HOT_MULTIPLIER, 16'd0);
		for (int s = 0; s < 8; s++)
			queue_random_set($urandom_range(1, 12));
		write_register(REG_DEAD_FRACTION, 16'd0);
		write_register(REG_HOT_MULTIPLIER, 16'hFFFF);
		for (int s = 0; s < 8; s++)
			queue_random_set($urandom_range(1, 12));
		write_register(REG_DEAD_FRACTION, 16'd32768);
		write_register(REG_HOT_MULTIPLIER, 16'd256);
		for (int s = 0; s < 8; s++)
			queue_random_set($urandom_range(1, 12));

		// Capacity overflow: one full set plus extra items, with the closing
		// item among the ignored ones.
		write_register(REG_DEAD_FRACTION, 16'd3277);
		write_register(REG_HOT_MULTIPLIER, 16'd1280);
		for (int k = 0; k < MAX_CH + 3; k++)
			queue_channel((k == 5) ? 32'd0 : $urandom_range(500, 700), k == MAX_CH + 2);

		// Random sets, mostly short; thresholds changed between phases.
		for (int phase = 0; phase < 4; phase++) begin
			write_register(REG_DEAD_FRACTION, 16'($urandom_range(0, 65535)));
			write_register(REG_HOT_MULTIPLIER, 16'($urandom_range(0, 2048)));
			if (phase == 3)
				calm_phase = 1'b1;
			for (int s = 0; s < 18; s++)
				queue_random_set($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 16) +
					(s == 0 ? 0 : 0));
		end

		while (pending_items.size() != 0 || expected_summaries.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
sv/dhc_pkg.sv
sv/dhc_ram.sv
sv/dhc_div.sv
sv/median_dead_hot_channel_classifier_core.sv
tb/testbench.sv
